@@ hdl/tbl_pkg.sv @@
// ----------------------------------------------------------------------------
// tbl_pkg
// shared constants, types and command/status structs for the line plotter
// ----------------------------------------------------------------------------
package tbl_pkg;

    localparam int ImageWidth  = 512;
    localparam int ImageHeight = 512;
    localparam int PlaneCount  = 3;

    localparam int XW       = $clog2(ImageWidth);
    localparam int YW       = $clog2(ImageHeight);
    localparam int PlaneW   = 2;
    localparam int MemDepth = PlaneCount * ImageWidth * ImageHeight;
    localparam int AddrW    = $clog2(MemDepth);

    localparam int CoordW = 11;
    // differences span 12 bits, squares 22, sums 23
    localparam int DiffW  = 12;
    localparam int SqW    = 24;
    localparam int LenW   = 12;
    // dx*i spans 12+12 bits signed
    localparam int ProdW  = 24;
    // stamped coordinates: center plus offset plus mirror, stay within 14 bits
    localparam int PtW    = 14;

    localparam logic CMD_STROKE = 1'b0;
    localparam logic CMD_READ   = 1'b1;

    localparam logic [1:0] REG_THICK  = 2'd0;
    localparam logic [1:0] REG_MIRROR = 2'd1;
    localparam logic [1:0] REG_ERASE  = 2'd2;
    localparam logic [1:0] REG_PLANE  = 2'd3;

    typedef struct packed {
        logic clr_start;   // begin clear sweep
        logic load;        // capture input transaction
        logic sqrt_start;  // begin length computation
        logic div_start;   // begin sample division
        logic samp_next;   // advance sample index
        logic off_init;    // reset offset scan
        logic off_next;    // advance offset / mirror scan
        logic rd_issue;    // issue pixel read
        logic res_load;    // move read data into the result register
    } tbl_cmd_t;

    typedef struct packed {
        logic clr_done;
        logic sqrt_done;
        logic div_done;
        logic samp_last;
        logic off_last;
    } tbl_sts_t;

endpackage

@@ hdl/tbl_ctrl.sv @@
// ----------------------------------------------------------------------------
// tbl_ctrl
// controller state machine sequencing clear, stroke and read transactions
// ----------------------------------------------------------------------------
module tbl_ctrl
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    input  logic             command,
    output logic             out_valid,
    input  logic             out_ready,
    output tbl_pkg::tbl_cmd_t cmd,
    input  tbl_pkg::tbl_sts_t sts
);

    localparam logic [2:0] ST_CLEAR = 3'd0;
    localparam logic [2:0] ST_IDLE  = 3'd1;
    localparam logic [2:0] ST_SQRT  = 3'd2;
    localparam logic [2:0] ST_DIV   = 3'd3;
    localparam logic [2:0] ST_STAMP = 3'd4;
    localparam logic [2:0] ST_READ  = 3'd5;
    localparam logic [2:0] ST_RESP  = 3'd6;
    localparam logic [2:0] ST_BOOT  = 3'd7;

    logic [2:0] state_reg, state_next;
    logic       out_valid_reg, out_valid_next;

    assign in_ready  = (state_reg == ST_IDLE);
    assign out_valid = out_valid_reg;

    always_comb
    begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg;
        cmd            = '0;
        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end
        unique case (state_reg)
            ST_BOOT:
            begin
                cmd.clr_start = 1'b1;
                state_next    = ST_CLEAR;
            end
            ST_CLEAR:
            begin
                if (sts.clr_done)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (in_valid && in_ready)
                begin
                    cmd.load = 1'b1;
                    if (command == tbl_pkg::CMD_STROKE)
                    begin
                        cmd.sqrt_start = 1'b1;
                        state_next     = ST_SQRT;
                    end
                    else
                    begin
                        state_next = ST_READ;
                    end
                end
            end
            ST_SQRT:
            begin
                if (sts.sqrt_done)
                begin
                    cmd.div_start = 1'b1;
                    state_next    = ST_DIV;
                end
            end
            ST_DIV:
            begin
                if (sts.div_done)
                begin
                    cmd.off_init = 1'b1;
                    state_next   = ST_STAMP;
                end
            end
            ST_STAMP:
            begin
                cmd.off_next = 1'b1;
                if (sts.off_last)
                begin
                    if (sts.samp_last)
                    begin
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        cmd.samp_next = 1'b1;
                        cmd.div_start = 1'b1;
                        state_next    = ST_DIV;
                    end
                end
            end
            ST_READ:
            begin
                cmd.rd_issue = 1'b1;
                state_next   = ST_RESP;
            end
            ST_RESP:
            begin
                // wait here while the result register still holds a transaction
                if (!out_valid_reg || out_ready)
                begin
                    cmd.res_load   = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_BOOT;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_BOOT;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

@@ hdl/tbl_datapath.sv @@
// ----------------------------------------------------------------------------
// tbl_datapath
// length square root, sample division, brush/mirror scan and bitmap memory
// ----------------------------------------------------------------------------
module tbl_datapath
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  tbl_pkg::tbl_cmd_t                 cmd,
    output tbl_pkg::tbl_sts_t                 sts,
    input  logic signed [tbl_pkg::CoordW-1:0] start_x,
    input  logic signed [tbl_pkg::CoordW-1:0] start_y,
    input  logic signed [tbl_pkg::CoordW-1:0] end_x,
    input  logic signed [tbl_pkg::CoordW-1:0] end_y,
    input  logic [1:0]                        read_plane,
    input  logic [5:0]                        thick,
    input  logic [1:0]                        mirror,
    input  logic                              erase,
    input  logic [1:0]                        plane,
    output logic                              pixel_value
);

    localparam int DW = tbl_pkg::DiffW;
    localparam int PW = tbl_pkg::ProdW;
    localparam int TW = tbl_pkg::PtW;
    localparam int AW = tbl_pkg::AddrW;

    // bitmap memory
    logic          mem [tbl_pkg::MemDepth];
    logic          wr_en;
    logic [AW-1:0] wr_addr;
    logic          wr_data;
    logic [AW-1:0] rd_addr;
    logic          rd_data_reg;
    logic          rd_ok_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    // clear sweep
    logic          clr_busy_reg;
    logic [AW-1:0] clr_cnt_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_busy_reg <= 1'b0;
            clr_cnt_reg  <= '0;
        end
        else if (cmd.clr_start)
        begin
            clr_busy_reg <= 1'b1;
            clr_cnt_reg  <= '0;
        end
        else if (clr_busy_reg)
        begin
            clr_cnt_reg <= clr_cnt_reg + AW'(1);
            if (clr_cnt_reg == AW'(tbl_pkg::MemDepth - 1))
            begin
                clr_busy_reg <= 1'b0;
            end
        end
    end

    assign sts.clr_done = clr_busy_reg && (clr_cnt_reg == AW'(tbl_pkg::MemDepth - 1));

    // captured transaction
    logic signed [DW-1:0] x1_reg, y1_reg, dx_reg, dy_reg;
    logic [1:0]           rplane_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            x1_reg     <= DW'(start_x);
            y1_reg     <= DW'(start_y);
            dx_reg     <= DW'(end_x) - DW'(start_x);
            dy_reg     <= DW'(end_y) - DW'(start_y);
            rplane_reg <= read_plane;
        end
    end

    // iterative square root, one result bit per pass over 12 passes
    logic [tbl_pkg::SqW-1:0] sq_n_reg;
    logic [tbl_pkg::SqW-1:0] sq_root_reg;
    logic [tbl_pkg::SqW-1:0] sq_bit_reg;
    logic                    sq_busy_reg;
    logic                    sq_phase_reg;
    logic [DW-1:0]           seg_len;
    logic [tbl_pkg::SqW-1:0] dsq_x, dsq_y;
    logic [tbl_pkg::SqW-1:0] sq_trial;

    assign sq_trial = sq_root_reg + sq_bit_reg;
    assign dsq_x    = tbl_pkg::SqW'(dx_reg) * tbl_pkg::SqW'(dx_reg);
    assign dsq_y    = tbl_pkg::SqW'(dy_reg) * tbl_pkg::SqW'(dy_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sq_busy_reg  <= 1'b0;
            sq_phase_reg <= 1'b0;
        end
        else if (cmd.sqrt_start)
        begin
            sq_busy_reg  <= 1'b1;
            sq_phase_reg <= 1'b0;
        end
        else if (sq_busy_reg)
        begin
            sq_phase_reg <= 1'b1;
            if (sq_phase_reg && sq_bit_reg == '0)
            begin
                sq_busy_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (sq_busy_reg && !sq_phase_reg)
        begin
            sq_n_reg    <= dsq_x + dsq_y;
            sq_root_reg <= '0;
            sq_bit_reg  <= tbl_pkg::SqW'(1) << (tbl_pkg::SqW - 2);
        end
        else if (sq_busy_reg && sq_bit_reg != '0)
        begin
            if (sq_n_reg >= sq_trial)
            begin
                sq_n_reg    <= sq_n_reg - sq_trial;
                sq_root_reg <= (sq_root_reg >> 1) + sq_bit_reg;
            end
            else
            begin
                sq_root_reg <= sq_root_reg >> 1;
            end
            sq_bit_reg <= sq_bit_reg >> 2;
        end
    end

    assign sts.sqrt_done = sq_busy_reg && sq_phase_reg && (sq_bit_reg == '0);

    always_comb
    begin
        seg_len = (sq_root_reg[DW-1:0] == '0) ? DW'(1) : sq_root_reg[DW-1:0];
    end

    // sample index and restoring floor division of dx*i and dy*i by len
    logic [DW-1:0]        idx_reg;
    logic [PW-1:0]        px_reg, py_reg;     // magnitudes
    logic                 nx_reg, ny_reg;     // signs
    logic [PW-1:0]        qx_reg, qy_reg;
    logic [DW:0]          remx_reg, remy_reg;
    logic [4:0]           dv_cnt_reg;
    logic                 dv_busy_reg;
    logic                 dv_mul_reg;
    logic signed [PW-1:0] prodx, prody;
    logic [DW:0]          rx_sh, ry_sh;
    logic signed [DW-1:0] cx_reg, cy_reg;

    assign prodx = PW'(dx_reg) * $signed({1'b0, idx_reg});
    assign prody = PW'(dy_reg) * $signed({1'b0, idx_reg});
    assign rx_sh = {remx_reg[DW-1:0], px_reg[PW-1]};
    assign ry_sh = {remy_reg[DW-1:0], py_reg[PW-1]};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dv_busy_reg <= 1'b0;
            dv_mul_reg  <= 1'b0;
            dv_cnt_reg  <= '0;
        end
        else if (cmd.div_start)
        begin
            dv_busy_reg <= 1'b1;
            dv_mul_reg  <= 1'b1;
            dv_cnt_reg  <= '0;
        end
        else if (dv_busy_reg)
        begin
            dv_mul_reg <= 1'b0;
            if (!dv_mul_reg)
            begin
                dv_cnt_reg <= dv_cnt_reg + 5'd1;
                if (dv_cnt_reg == 5'(PW))
                begin
                    dv_busy_reg <= 1'b0;
                end
            end
        end
    end

    assign sts.div_done = dv_busy_reg && !dv_mul_reg && (dv_cnt_reg == 5'(PW));

    always_ff @(posedge clk)
    begin
        if (cmd.sqrt_start)
        begin
            idx_reg <= '0;
        end
        else if (cmd.samp_next)
        begin
            idx_reg <= idx_reg + DW'(1);
        end
        if (dv_busy_reg && dv_mul_reg)
        begin
            nx_reg   <= prodx[PW-1];
            ny_reg   <= prody[PW-1];
            px_reg   <= prodx[PW-1] ? PW'(-prodx) : PW'(prodx);
            py_reg   <= prody[PW-1] ? PW'(-prody) : PW'(prody);
            qx_reg   <= '0;
            qy_reg   <= '0;
            remx_reg <= '0;
            remy_reg <= '0;
        end
        else if (dv_busy_reg && dv_cnt_reg < 5'(PW))
        begin
            px_reg <= px_reg << 1;
            py_reg <= py_reg << 1;
            if (rx_sh >= {1'b0, seg_len})
            begin
                remx_reg <= rx_sh - {1'b0, seg_len};
                qx_reg   <= {qx_reg[PW-2:0], 1'b1};
            end
            else
            begin
                remx_reg <= rx_sh;
                qx_reg   <= {qx_reg[PW-2:0], 1'b0};
            end
            if (ry_sh >= {1'b0, seg_len})
            begin
                remy_reg <= ry_sh - {1'b0, seg_len};
                qy_reg   <= {qy_reg[PW-2:0], 1'b1};
            end
            else
            begin
                remy_reg <= ry_sh;
                qy_reg   <= {qy_reg[PW-2:0], 1'b0};
            end
        end
        else if (sts.div_done)
        begin
            // floor for negative quotients: negate and subtract one on remainder
            cx_reg <= x1_reg + (nx_reg ? (-DW'(qx_reg) - DW'(remx_reg != '0))
                                       : DW'(qx_reg));
            cy_reg <= y1_reg + (ny_reg ? (-DW'(qy_reg) - DW'(remy_reg != '0))
                                       : DW'(qy_reg));
        end
    end

    assign sts.samp_last = (idx_reg + DW'(1)) >= seg_len;

    // brush offset and mirror scan
    logic signed [7:0] ox_reg, oy_reg;
    logic [1:0]        mir_reg;
    logic signed [7:0] r_s;
    logic [13:0]       r2;
    logic [13:0]       d2;
    logic              in_disc;
    logic              mir_en;
    logic              last_off;
    logic signed [TW-1:0] px, py, mx, my;
    logic              on_img;
    logic [AW-1:0]     pix_addr;

    assign r_s     = $signed({2'b00, thick}) - 8'sd1;
    assign r2      = 14'(r_s) * 14'(r_s);
    assign d2      = 14'(ox_reg) * 14'(ox_reg) + 14'(oy_reg) * 14'(oy_reg);
    assign in_disc = (thick == 6'd1) ? 1'b1 : ((thick != 6'd0) && (d2 < r2));

    always_comb
    begin
        unique case (mir_reg)
            2'd0:    mir_en = 1'b1;
            2'd1:    mir_en = mirror[0];
            2'd2:    mir_en = mirror[1];
            default: mir_en = (mirror == 2'd3);
        endcase
    end

    always_comb
    begin
        if (thick <= 6'd1)
        begin
            last_off = (mir_reg == 2'd3);
        end
        else
        begin
            last_off = (mir_reg == 2'd3) && (ox_reg == r_s - 8'sd1)
                       && (oy_reg == r_s - 8'sd1);
        end
    end

    assign sts.off_last = last_off;

    assign px = TW'(cx_reg) + TW'(ox_reg);
    assign py = TW'(cy_reg) + TW'(oy_reg);
    assign mx = mir_reg[0] ? (TW'(tbl_pkg::ImageWidth) - px) : px;
    assign my = mir_reg[1] ? (TW'(tbl_pkg::ImageHeight) - py) : py;
    assign on_img = (mx >= 0) && (mx < TW'(tbl_pkg::ImageWidth))
                    && (my >= 0) && (my < TW'(tbl_pkg::ImageHeight));
    assign pix_addr = AW'(plane) * AW'(tbl_pkg::ImageWidth * tbl_pkg::ImageHeight)
                      + AW'(my[tbl_pkg::YW-1:0]) * AW'(tbl_pkg::ImageWidth)
                      + AW'(mx[tbl_pkg::XW-1:0]);

    always_ff @(posedge clk)
    begin
        if (cmd.off_init)
        begin
            mir_reg <= '0;
            ox_reg  <= (thick <= 6'd1) ? 8'sd0 : -r_s;
            oy_reg  <= (thick <= 6'd1) ? 8'sd0 : -r_s;
        end
        else if (cmd.off_next)
        begin
            mir_reg <= mir_reg + 2'd1;
            if (mir_reg == 2'd3 && thick > 6'd1)
            begin
                if (oy_reg == r_s - 8'sd1)
                begin
                    oy_reg <= -r_s;
                    ox_reg <= ox_reg + 8'sd1;
                end
                else
                begin
                    oy_reg <= oy_reg + 8'sd1;
                end
            end
        end
    end

    // memory port selection
    always_comb
    begin
        wr_en   = 1'b0;
        wr_addr = pix_addr;
        wr_data = !erase;
        if (clr_busy_reg)
        begin
            wr_en   = 1'b1;
            wr_addr = clr_cnt_reg;
            wr_data = 1'b0;
        end
        else if (cmd.off_next)
        begin
            wr_en = in_disc && mir_en && on_img && (thick != 6'd0)
                    && (plane < 2'(tbl_pkg::PlaneCount));
        end
    end

    logic rd_ok;

    assign rd_ok = (rplane_reg < 2'(tbl_pkg::PlaneCount)) && (x1_reg >= 0) && (y1_reg >= 0)
                   && (x1_reg < DW'(tbl_pkg::ImageWidth))
                   && (y1_reg < DW'(tbl_pkg::ImageHeight));
    assign rd_addr = AW'(rplane_reg) * AW'(tbl_pkg::ImageWidth * tbl_pkg::ImageHeight)
                     + AW'(y1_reg[tbl_pkg::YW-1:0]) * AW'(tbl_pkg::ImageWidth)
                     + AW'(x1_reg[tbl_pkg::XW-1:0]);

    logic pix_reg_hold;

    always_ff @(posedge clk)
    begin
        if (cmd.rd_issue)
        begin
            rd_ok_reg <= rd_ok;
        end
        if (cmd.res_load)
        begin
            pix_reg_hold <= rd_data_reg && rd_ok_reg;
        end
    end

    assign pixel_value = pix_reg_hold;

endmodule

@@ hdl/thick_brush_line_plotter.sv @@
// ----------------------------------------------------------------------------
// thick_brush_line_plotter
// thick disc-brush segment rasterizer over one-bit bitmap planes
// ----------------------------------------------------------------------------
// channel  direction  handshake          payload
// input    in         in_valid/ready     command, start_x/y, end_x/y, read_plane
// output   out        out_valid/ready    pixel_value
// config   in         apb psel/penable   paddr, pwdata, prdata
//
// after reset a clear pass writes all PlaneCount*W*H bits (786432), one per cycle,
// before the first transaction is taken
// a read steps through the READ and RESP states, fetching the pixel and then
// registering it as the result; input is taken again together with the result
// a stroke runs the bit-serial root once, then per sample the bit-serial divider
// and the brush/mirror scan, writing at most one pixel per cycle to the bitmap port
// a pending result stalls only a following read, which waits for the output slot
// ----------------------------------------------------------------------------
module thick_brush_line_plotter
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic               command,
    input  logic signed [10:0] start_x,
    input  logic signed [10:0] start_y,
    input  logic signed [10:0] end_x,
    input  logic signed [10:0] end_y,
    input  logic [1:0]         read_plane,
    output logic               out_valid,
    input  logic               out_ready,
    output logic               pixel_value,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [3:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);

    tbl_pkg::tbl_cmd_t cmd;
    tbl_pkg::tbl_sts_t sts;

    logic [5:0] thick_reg;
    logic [1:0] mirror_reg;
    logic       erase_reg;
    logic [1:0] plane_reg;
    logic       wr;

    assign pready = 1'b1;
    assign wr     = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thick_reg  <= 6'd5;
            mirror_reg <= 2'd0;
            erase_reg  <= 1'b0;
            plane_reg  <= 2'd0;
        end
        else if (wr && paddr[1:0] == 2'b00)
        begin
            unique case (paddr[3:2])
                tbl_pkg::REG_THICK:  thick_reg  <= pwdata[5:0];
                tbl_pkg::REG_MIRROR: mirror_reg <= pwdata[1:0];
                tbl_pkg::REG_ERASE:  erase_reg  <= pwdata[0];
                default:             plane_reg  <= pwdata[1:0];
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[3:2])
            tbl_pkg::REG_THICK:  prdata = {26'd0, thick_reg};
            tbl_pkg::REG_MIRROR: prdata = {30'd0, mirror_reg};
            tbl_pkg::REG_ERASE:  prdata = {31'd0, erase_reg};
            default:             prdata = {30'd0, plane_reg};
        endcase
    end

    tbl_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .command   (command),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .cmd       (cmd),
        .sts       (sts)
    );

    tbl_datapath u_dp
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .sts         (sts),
        .start_x     (start_x),
        .start_y     (start_y),
        .end_x       (end_x),
        .end_y       (end_y),
        .read_plane  (read_plane),
        .thick       (thick_reg),
        .mirror      (mirror_reg),
        .erase       (erase_reg),
        .plane       (plane_reg),
        .pixel_value (pixel_value)
    );

`ifndef SYNTH
    a_result_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> (out_valid && $stable(pixel_value)))
        else $error("result dropped under stall");
    a_load_only_on_accept: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load |-> (in_valid && in_ready))
        else $error("load without transaction");
`endif

endmodule
